// ----- hw/rtl/qvr_pkg.sv -----
// ----------------------------------------------------------------------------
// qvr_pkg
// Shared widths, command codes and transaction types for the quaternion
// vector rotation pipeline.
// ----------------------------------------------------------------------------
package qvr_pkg;

  localparam int VEC_WIDTH  = 24;
  localparam int QUAT_WIDTH = 16;

  localparam int PROD_WIDTH = 2 * QUAT_WIDTH;
  localparam int MAT_WIDTH  = PROD_WIDTH + 2;
  localparam int MV_WIDTH   = MAT_WIDTH + VEC_WIDTH;
  localparam int SUM_WIDTH  = MV_WIDTH + 2;
  localparam int FRAC_BITS  = 2 * (QUAT_WIDTH - 2);
  localparam int ACC_WIDTH  = SUM_WIDTH - FRAC_BITS;

  localparam logic CMD_FORWARD = 1'b0;
  localparam logic CMD_INVERSE = 1'b1;

  localparam logic signed [VEC_WIDTH-1:0] VEC_MAX = {1'b0, {(VEC_WIDTH-1){1'b1}}};
  localparam logic signed [VEC_WIDTH-1:0] VEC_MIN = {1'b1, {(VEC_WIDTH-1){1'b0}}};

  typedef struct packed {
    logic                          command;
    logic signed [QUAT_WIDTH-1:0]  quat_w;
    logic signed [QUAT_WIDTH-1:0]  quat_x;
    logic signed [QUAT_WIDTH-1:0]  quat_y;
    logic signed [QUAT_WIDTH-1:0]  quat_z;
    logic signed [VEC_WIDTH-1:0]   vec_x;
    logic signed [VEC_WIDTH-1:0]   vec_y;
    logic signed [VEC_WIDTH-1:0]   vec_z;
  } qvr_request_t;

  typedef struct packed {
    logic signed [VEC_WIDTH-1:0] out_x;
    logic signed [VEC_WIDTH-1:0] out_y;
    logic signed [VEC_WIDTH-1:0] out_z;
    logic                        saturated;
  } qvr_result_t;

endpackage

// ----- hw/rtl/quaternion_vector_rotate.sv -----
// ----------------------------------------------------------------------------
// quaternion_vector_rotate
// Rotates a 3-vector by a Q2.14 quaternion, forward (q v q*) or inverse
// (q* v q), with one final rounding and saturation to the vector width.
// ----------------------------------------------------------------------------
// The block takes one transaction in every clock cycle and never raises busy.
// Each result appears on the result port with done high, in the order the
// transactions arrived. The five pipeline stages are the quaternion component
// products, the rotation matrix sums, the matrix by vector multiplies, the row
// sums with rounding, and the final clamp. The receiver must take each result
// in the cycle in which done is high.
module quaternion_vector_rotate
  import qvr_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  output logic         busy,
  input  qvr_request_t request,
  output logic         done,
  output qvr_result_t  result
);

  localparam logic [SUM_WIDTH-1:0] ROUND_HALF = SUM_WIDTH'(1) << (FRAC_BITS - 1);

  logic accept;

  logic                         v1, v2, v3, v4;
  logic                         s1_command;
  logic signed [PROD_WIDTH-1:0] ww, xx, yy, zz, xy, xz, yz, wx, wy, wz;
  logic signed [VEC_WIDTH-1:0]  s1_vec [3];
  logic signed [VEC_WIDTH-1:0]  s2_vec [3];
  logic signed [MAT_WIDTH-1:0]  mat [3][3];
  logic signed [MV_WIDTH-1:0]   prod [3][3];
  logic        [ACC_WIDTH-1:0]  acc [3];

  logic signed [MAT_WIDTH-1:0]  mat_next [3][3];
  logic signed [MAT_WIDTH-1:0]  d_xy_wz, s_xy_wz, s_xz_wy, d_xz_wy, d_yz_wx, s_yz_wx;
  logic signed [MAT_WIDTH-1:0]  m01, m10, m02, m20, m12, m21;
  logic        [SUM_WIDTH-1:0]  row_sum [3];
  logic signed [VEC_WIDTH-1:0]  comp_next [3];
  logic        [2:0]            clamp;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      v4   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= accept;
      v2   <= v1;
      v3   <= v2;
      v4   <= v3;
      done <= v4;
    end
  end

  always_ff @(posedge clk) begin
    s1_command <= request.command;
    ww <= request.quat_w * request.quat_w;
    xx <= request.quat_x * request.quat_x;
    yy <= request.quat_y * request.quat_y;
    zz <= request.quat_z * request.quat_z;
    xy <= request.quat_x * request.quat_y;
    xz <= request.quat_x * request.quat_z;
    yz <= request.quat_y * request.quat_z;
    wx <= request.quat_w * request.quat_x;
    wy <= request.quat_w * request.quat_y;
    wz <= request.quat_w * request.quat_z;
    s1_vec[0] <= request.vec_x;
    s1_vec[1] <= request.vec_y;
    s1_vec[2] <= request.vec_z;
  end

  always_comb begin
    d_xy_wz = MAT_WIDTH'(xy) - MAT_WIDTH'(wz);
    s_xy_wz = MAT_WIDTH'(xy) + MAT_WIDTH'(wz);
    s_xz_wy = MAT_WIDTH'(xz) + MAT_WIDTH'(wy);
    d_xz_wy = MAT_WIDTH'(xz) - MAT_WIDTH'(wy);
    d_yz_wx = MAT_WIDTH'(yz) - MAT_WIDTH'(wx);
    s_yz_wx = MAT_WIDTH'(yz) + MAT_WIDTH'(wx);
    m01 = {d_xy_wz[MAT_WIDTH-2:0], 1'b0};
    m10 = {s_xy_wz[MAT_WIDTH-2:0], 1'b0};
    m02 = {s_xz_wy[MAT_WIDTH-2:0], 1'b0};
    m20 = {d_xz_wy[MAT_WIDTH-2:0], 1'b0};
    m12 = {d_yz_wx[MAT_WIDTH-2:0], 1'b0};
    m21 = {s_yz_wx[MAT_WIDTH-2:0], 1'b0};
    mat_next[0][0] = MAT_WIDTH'(ww) + MAT_WIDTH'(xx) - MAT_WIDTH'(yy) - MAT_WIDTH'(zz);
    mat_next[1][1] = MAT_WIDTH'(ww) - MAT_WIDTH'(xx) + MAT_WIDTH'(yy) - MAT_WIDTH'(zz);
    mat_next[2][2] = MAT_WIDTH'(ww) - MAT_WIDTH'(xx) - MAT_WIDTH'(yy) + MAT_WIDTH'(zz);
    if (s1_command == CMD_INVERSE) begin
      mat_next[0][1] = m10;
      mat_next[1][0] = m01;
      mat_next[0][2] = m20;
      mat_next[2][0] = m02;
      mat_next[1][2] = m21;
      mat_next[2][1] = m12;
    end else begin
      mat_next[0][1] = m01;
      mat_next[1][0] = m10;
      mat_next[0][2] = m02;
      mat_next[2][0] = m20;
      mat_next[1][2] = m12;
      mat_next[2][1] = m21;
    end
  end

  always_ff @(posedge clk) begin
    mat    <= mat_next;
    s2_vec <= s1_vec;
  end

  always_ff @(posedge clk) begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod[r][c] <= mat[r][c] * s2_vec[c];
      end
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      row_sum[r] = SUM_WIDTH'(prod[r][0]) + SUM_WIDTH'(prod[r][1])
                 + SUM_WIDTH'(prod[r][2]) + ROUND_HALF;
    end
  end

  always_ff @(posedge clk) begin
    for (int r = 0; r < 3; r++) begin
      acc[r] <= row_sum[r][SUM_WIDTH-1:FRAC_BITS];
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      clamp[r] = !((&acc[r][ACC_WIDTH-1:VEC_WIDTH-1]) || !(|acc[r][ACC_WIDTH-1:VEC_WIDTH-1]));
      if (!clamp[r]) begin
        comp_next[r] = acc[r][VEC_WIDTH-1:0];
      end else if (acc[r][ACC_WIDTH-1]) begin
        comp_next[r] = VEC_MIN;
      end else begin
        comp_next[r] = VEC_MAX;
      end
    end
  end

  always_ff @(posedge clk) begin
    result.out_x     <= comp_next[0];
    result.out_y     <= comp_next[1];
    result.out_z     <= comp_next[2];
    result.saturated <= |clamp;
  end

  a_latency : assert property (@(posedge clk) disable iff (rst)
    accept |-> ##5 done)
    else $error("Accepted transaction did not complete after five cycles.");

  a_no_spurious : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, 5))
    else $error("Result strobe without a matching accepted transaction.");

  a_sat_clamped : assert property (@(posedge clk) disable iff (rst)
    done && result.saturated |->
      (result.out_x == VEC_MAX || result.out_x == VEC_MIN ||
       result.out_y == VEC_MAX || result.out_y == VEC_MIN ||
       result.out_z == VEC_MAX || result.out_z == VEC_MIN))
    else $error("Saturation flagged but no component sits at a clamp value.");

  a_zero_quat : assert property (@(posedge clk) disable iff (rst)
    accept && request.quat_w == '0 && request.quat_x == '0 &&
    request.quat_y == '0 && request.quat_z == '0 |->
      ##5 (result.out_x == '0 && result.out_y == '0 &&
           result.out_z == '0 && !result.saturated))
    else $error("Zero quaternion did not give a zero vector.");

endmodule

// ----- dv/quaternion_vector_rotate_test.sv -----
// ----------------------------------------------------------------------------
// quaternion_vector_rotate_test
// Self-checking testbench for the quaternion vector rotation pipeline. Each
// accepted transaction is predicted with exact integer arithmetic and checked
// field by field against the results in arrival order, under bursty stimulus.
// ----------------------------------------------------------------------------
module quaternion_vector_rotate_test;
  import qvr_pkg::*;

  localparam int PIPE_LATENCY = 5;
  localparam int CYCLE_LIMIT  = 100000;
  localparam logic signed [QUAT_WIDTH-1:0] Q_ONE  = 16'sd16384;
  localparam logic signed [QUAT_WIDTH-1:0] Q_COS45 = 16'sd11585;

  logic         clk;
  logic         rst;
  logic         start;
  logic         busy;
  qvr_request_t request;
  logic         done;
  qvr_result_t  result;

  qvr_result_t  expected_rotations[$];
  int           error_count;
  int           cycle_count;
  int           burst_left;

  quaternion_vector_rotate DUT (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic qvr_result_t rotate_vector(qvr_request_t req);
    longint w, x, y, z;
    longint v[3];
    longint m[3][3];
    longint t, acc;
    qvr_result_t res;
    logic signed [VEC_WIDTH-1:0] comp[3];
    w = req.quat_w;
    x = req.quat_x;
    y = req.quat_y;
    z = req.quat_z;
    v[0] = req.vec_x;
    v[1] = req.vec_y;
    v[2] = req.vec_z;
    m[0][0] = w * w + x * x - y * y - z * z;
    m[1][1] = w * w - x * x + y * y - z * z;
    m[2][2] = w * w - x * x - y * y + z * z;
    m[0][1] = 2 * (x * y - w * z);
    m[1][0] = 2 * (x * y + w * z);
    m[0][2] = 2 * (x * z + w * y);
    m[2][0] = 2 * (x * z - w * y);
    m[1][2] = 2 * (y * z - w * x);
    m[2][1] = 2 * (y * z + w * x);
    // The inverse rotation uses the transposed matrix.
    if (req.command == CMD_INVERSE) begin
      t = m[0][1]; m[0][1] = m[1][0]; m[1][0] = t;
      t = m[0][2]; m[0][2] = m[2][0]; m[2][0] = t;
      t = m[1][2]; m[1][2] = m[2][1]; m[2][1] = t;
    end
    res.saturated = 1'b0;
    for (int r = 0; r < 3; r++) begin
      acc = m[r][0] * v[0] + m[r][1] * v[1] + m[r][2] * v[2];
      acc = (acc + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
      if (acc > longint'(VEC_MAX)) begin
        comp[r] = VEC_MAX;
        res.saturated = 1'b1;
      end else if (acc < longint'(VEC_MIN)) begin
        comp[r] = VEC_MIN;
        res.saturated = 1'b1;
      end else begin
        comp[r] = acc[VEC_WIDTH-1:0];
      end
    end
    res.out_x = comp[0];
    res.out_y = comp[1];
    res.out_z = comp[2];
    return res;
  endfunction

  function automatic qvr_request_t make_request(logic cmd, int w, int x, int y, int z,
                                                int vx, int vy, int vz);
    qvr_request_t req;
    req.command = cmd;
    req.quat_w  = QUAT_WIDTH'(w);
    req.quat_x  = QUAT_WIDTH'(x);
    req.quat_y  = QUAT_WIDTH'(y);
    req.quat_z  = QUAT_WIDTH'(z);
    req.vec_x   = VEC_WIDTH'(vx);
    req.vec_y   = VEC_WIDTH'(vy);
    req.vec_z   = VEC_WIDTH'(vz);
    return req;
  endfunction

  // Holds start high until the transaction is taken, then records its result.
  task automatic send_rotation(qvr_request_t req);
    start   <= 1'b1;
    request <= req;
    do @(posedge clk); while (busy);
    expected_rotations.push_back(rotate_vector(req));
  endtask

  task automatic idle_cycles(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic send_paced(qvr_request_t req);
    int gap;
    send_rotation(req);
    burst_left--;
    if (burst_left <= 0) begin
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) idle_cycles(gap);
      burst_left = ($urandom_range(4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    end
  endtask

  task automatic wait_for_results();
    start <= 1'b0;
    do @(posedge clk); while (expected_rotations.size() != 0);
    repeat (PIPE_LATENCY + 2) @(posedge clk);
  endtask

  task automatic test_identity_and_zero();
    send_paced(make_request(CMD_FORWARD, 0, 0, 0, 0, 8388607, -8388608, 8388607));
    send_paced(make_request(CMD_INVERSE, 0, 0, 0, 0, -1, 1, -8388608));
    send_paced(make_request(CMD_FORWARD, Q_ONE, 0, 0, 0, 8388607, -8388608, 1));
    send_paced(make_request(CMD_INVERSE, Q_ONE, 0, 0, 0, -8388608, 8388607, -1));
  endtask

  task automatic test_quarter_turn();
    send_paced(make_request(CMD_FORWARD, Q_COS45, 0, 0, Q_COS45, 1000000, 0, 0));
    send_paced(make_request(CMD_INVERSE, Q_COS45, 0, 0, Q_COS45, 1000000, 0, 0));
    send_paced(make_request(CMD_FORWARD, Q_COS45, Q_COS45, 0, 0, 0, -2000000, 300));
    send_paced(make_request(CMD_INVERSE, Q_COS45, 0, -Q_COS45, 0, 12345, 67890, -4242));
  endtask

  task automatic test_field_extremes();
    send_paced(make_request(CMD_FORWARD, 32767, 32767, 32767, 32767, 8388607, 8388607,
                            8388607));
    send_paced(make_request(CMD_INVERSE, -32768, -32768, -32768, -32768, -8388608,
                            -8388608, -8388608));
    send_paced(make_request(CMD_FORWARD, -32768, 32767, -32768, 32767, 0, 0, 0));
    send_paced(make_request(CMD_INVERSE, 32767, -32768, 32767, -32768, 1, -1, 1));
  endtask

  // An exact half rounds toward plus infinity.
  task automatic test_rounding();
    send_paced(make_request(CMD_FORWARD, 128, 0, 0, 0, 8192, -8192, 24576));
    send_paced(make_request(CMD_INVERSE, 128, 0, 0, 0, -24576, 8191, -8193));
    send_paced(make_request(CMD_FORWARD, 1, 0, 0, 0, 1, -1, 134));
  endtask

  // A non-unit quaternion scales the vector by its squared norm.
  task automatic test_saturation();
    send_paced(make_request(CMD_FORWARD, -32768, 0, 0, 0, 8388607, -8388608, 100));
    send_paced(make_request(CMD_INVERSE, -32768, 0, 0, 0, 8388607, -8388608, 100));
    send_paced(make_request(CMD_FORWARD, 23170, 0, 0, 0, 4194304, -4194304, 4194303));
    send_paced(make_request(CMD_INVERSE, 20000, 9000, -7000, 3000, 8000000, -8000000,
                            5000000));
  endtask

  task automatic test_random_full_range(int count);
    qvr_request_t req;
    repeat (count) begin
      req.command = 1'($urandom_range(1));
      req.quat_w  = QUAT_WIDTH'($urandom);
      req.quat_x  = QUAT_WIDTH'($urandom);
      req.quat_y  = QUAT_WIDTH'($urandom);
      req.quat_z  = QUAT_WIDTH'($urandom);
      req.vec_x   = VEC_WIDTH'($urandom);
      req.vec_y   = VEC_WIDTH'($urandom);
      req.vec_z   = VEC_WIDTH'($urandom);
      send_paced(req);
    end
  endtask

  // Quaternion components no larger than cos 45 degrees in size, with full-range or small vectors.
  task automatic test_random_moderate(int count);
    qvr_request_t req;
    int span;
    repeat (count) begin
      span = ($urandom_range(3) == 0) ? 4095 : 8388607;
      req.command = 1'($urandom_range(1));
      req.quat_w  = QUAT_WIDTH'(int'($urandom_range(2 * Q_COS45)) - Q_COS45);
      req.quat_x  = QUAT_WIDTH'(int'($urandom_range(2 * Q_COS45)) - Q_COS45);
      req.quat_y  = QUAT_WIDTH'(int'($urandom_range(2 * Q_COS45)) - Q_COS45);
      req.quat_z  = QUAT_WIDTH'(int'($urandom_range(2 * Q_COS45)) - Q_COS45);
      req.vec_x   = VEC_WIDTH'(int'($urandom_range(2 * span)) - span);
      req.vec_y   = VEC_WIDTH'(int'($urandom_range(2 * span)) - span);
      req.vec_z   = VEC_WIDTH'(int'($urandom_range(2 * span)) - span);
      send_paced(req);
    end
  endtask

  always @(posedge clk) begin
    qvr_result_t exp_res;
    if (!rst && done) begin
      if (expected_rotations.size() == 0) begin
        $error("Unexpected result transaction: out_x %0d out_y %0d out_z %0d",
               result.out_x, result.out_y, result.out_z);
        error_count++;
      end else begin
        exp_res = expected_rotations.pop_front();
        if (result.out_x !== exp_res.out_x) begin
          $error("out_x mismatch: expected %0d, actual %0d", exp_res.out_x, result.out_x);
          error_count++;
        end
        if (result.out_y !== exp_res.out_y) begin
          $error("out_y mismatch: expected %0d, actual %0d", exp_res.out_y, result.out_y);
          error_count++;
        end
        if (result.out_z !== exp_res.out_z) begin
          $error("out_z mismatch: expected %0d, actual %0d", exp_res.out_z, result.out_z);
          error_count++;
        end
        if (result.saturated !== exp_res.saturated) begin
          $error("saturated mismatch: expected %0d, actual %0d", exp_res.saturated,
                 result.saturated);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    error_count = 0;
    cycle_count = 0;
    burst_left  = 1;
    rst     <= 1'b1;
    start   <= 1'b0;
    request <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_identity_and_zero();
    test_quarter_turn();
    test_field_extremes();
    test_rounding();
    test_saturation();
    wait_for_results();
    test_random_full_range(350);
    wait_for_results();
    test_random_moderate(600);
    wait_for_results();

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/qvr_pkg.sv
hw/rtl/quaternion_vector_rotate.sv
dv/quaternion_vector_rotate_test.sv
